>>> hdl/gpw_pkg.sv
// Package for the glyph pixel writer: codes, reset values and the structs
// used by the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package gpw_pkg;

    localparam int GLYPH_ROWS      = 8;
    localparam int GLYPH_COUNT_DEF = 256;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_GLYPH = 2'd1;
    localparam logic [1:0] ACT_PIXEL = 2'd2;

    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_RGB     = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;

    localparam logic [1:0] CNT_INDEXED = 2'd1;
    localparam logic [1:0] CNT_TEXT    = 2'd2;
    localparam logic [1:0] CNT_RGB     = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_PBYTES = 3'd4;
    localparam logic [2:0] REG_RED    = 3'd5;
    localparam logic [2:0] REG_GREEN  = 3'd6;
    localparam logic [2:0] REG_BLUE   = 3'd7;

    typedef struct packed {
        logic [1:0]  frame_mode;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] line_pitch;
        logic [2:0]  pixel_bytes;
        logic [4:0]  red_shift;
        logic [4:0]  green_shift;
        logic [4:0]  blue_shift;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        frame_mode:   MODE_TEXT,
        frame_width:  13'd80,
        frame_height: 13'd25,
        line_pitch:   16'd160,
        pixel_bytes:  3'd2,
        red_shift:    5'd16,
        green_shift:  5'd8,
        blue_shift:   5'd0
    };

    typedef struct packed {
        logic [27:0] byte_offset;
        logic [1:0]  byte_count;
        logic [7:0]  byte_first;
        logic [7:0]  byte_second;
        logic [7:0]  byte_third;
    } t_wr;

    typedef struct packed {
        logic take;
        logic setup;
        logic ram_we;
        logic rd_en;
        logic step;
        logic push;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       code_ok;
        logic       origin_in;
        logic       pix_mode;
        logic       text_mode;
        logic       hit;
        logic       col_last;
        logic       row_last;
        logic       pend_valid;
        logic       out_free;
        logic       can_push;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/gpw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module gpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/gpw_ctrl.sv
// Controller of the glyph pixel writer: sequences load, single write and
// glyph scan. Depends on gpw_pkg for the command and status structs.
`default_nettype none

module gpw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire gpw_pkg::t_sts i_sts,
    output gpw_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SINGLE   = 5'b00100,
        S_SCAN     = 5'b01000,
        S_FLUSH    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.setup = 1'b1;
                n_state     = S_IDLE;
                case (i_sts.action)
                    gpw_pkg::ACT_LOAD: begin
                        o_cmd.ram_we = i_sts.code_ok;
                    end
                    gpw_pkg::ACT_GLYPH: begin
                        if (i_sts.origin_in) begin
                            if (i_sts.text_mode) begin
                                n_state = S_SINGLE;
                            end else if (i_sts.pix_mode && i_sts.code_ok) begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = S_SCAN;
                            end
                        end
                    end
                    gpw_pkg::ACT_PIXEL: begin
                        if (i_sts.pix_mode && i_sts.origin_in) begin
                            n_state = S_SINGLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SINGLE: begin
                o_cmd.push = 1'b1;
                n_state    = S_FLUSH;
            end
            S_SCAN: begin
                if (!i_sts.hit || i_sts.can_push) begin
                    o_cmd.step  = 1'b1;
                    o_cmd.push  = i_sts.hit;
                    o_cmd.rd_en = i_sts.col_last && !i_sts.row_last;
                    if (i_sts.col_last && i_sts.row_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/gpw_dp.sv
// Datapath of the glyph pixel writer: item registers, font RAM, offset
// arithmetic, scan counters, one held-back write and the output register.
// Depends on gpw_pkg and gpw_ram.
`default_nettype none

module gpw_dp #(
    parameter int GLYPH_COUNT = gpw_pkg::GLYPH_COUNT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gpw_pkg::t_cfg                    i_cfg,
    input  wire logic [gpw_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  wire logic [gpw_pkg::IN_USER_W-1:0]    i_s_tuser,
    input  wire gpw_pkg::t_cmd                    i_cmd,
    output gpw_pkg::t_sts                         o_sts,
    input  wire logic                             i_m_tready,
    output logic                                  o_m_tvalid,
    output logic      [gpw_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int DEPTH  = GLYPH_COUNT * gpw_pkg::GLYPH_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [1:0]  r_action;
    logic [7:0]  r_code;
    logic [11:0] r_x;
    logic [11:0] r_y;
    logic [31:0] r_colour;
    logic [2:0]  r_grow;
    logic [7:0]  r_bits;
    logic [12:0] r_cx;
    logic [12:0] r_cy;
    logic [2:0]  r_c;
    logic [2:0]  r_r;
    logic [27:0] r_row_off;
    logic [14:0] r_col_base;
    logic [15:0] r_col_off;
    logic [27:0] r_text_off;
    gpw_pkg::t_wr r_pend;
    logic         r_pend_valid;
    gpw_pkg::t_wr r_out;
    logic         r_out_valid;
    logic         r_out_last;

    logic [7:0]        w_font;
    logic [2:0]        w_rd_row;
    logic [24:0]       w_yw;
    logic [25:0]       w_text_sum;
    logic [31:0]       w_red;
    logic [31:0]       w_green;
    logic [31:0]       w_blue;
    gpw_pkg::t_wr      w_cand;
    logic              w_out_free;
    logic              w_can_push;

    assign w_rd_row = i_cmd.step ? r_r + 3'd1 : r_r;

    gpw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (ADDR_W'({r_code, r_grow})),
        .i_wdata (r_bits),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ADDR_W'({r_code, w_rd_row})),
        .o_rdata (w_font)
    );

    assign w_yw       = r_y * i_cfg.frame_width;
    assign w_text_sum = {1'b0, w_yw} + 26'(r_x);
    assign w_red      = r_colour >> i_cfg.red_shift;
    assign w_green    = r_colour >> i_cfg.green_shift;
    assign w_blue     = r_colour >> i_cfg.blue_shift;

    always_comb begin
        w_cand.byte_offset = r_row_off + 28'(r_col_off);
        w_cand.byte_count  = gpw_pkg::CNT_INDEXED;
        w_cand.byte_first  = r_colour[7:0];
        w_cand.byte_second = 8'd0;
        w_cand.byte_third  = 8'd0;
        if (i_cfg.frame_mode == gpw_pkg::MODE_TEXT) begin
            w_cand.byte_offset = r_text_off;
            w_cand.byte_count  = gpw_pkg::CNT_TEXT;
            w_cand.byte_first  = r_code;
            w_cand.byte_second = r_colour[7:0];
        end else if (i_cfg.frame_mode == gpw_pkg::MODE_RGB) begin
            w_cand.byte_count  = gpw_pkg::CNT_RGB;
            w_cand.byte_first  = w_red[7:0];
            w_cand.byte_second = w_green[7:0];
            w_cand.byte_third  = w_blue[7:0];
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_can_push = !r_pend_valid || w_out_free;

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_action;
        o_sts.code_ok    = 32'(r_code) < GLYPH_COUNT;
        o_sts.origin_in  = ({1'b0, r_x} < i_cfg.frame_width)
                        && ({1'b0, r_y} < i_cfg.frame_height);
        o_sts.pix_mode   = (i_cfg.frame_mode == gpw_pkg::MODE_INDEXED)
                        || (i_cfg.frame_mode == gpw_pkg::MODE_RGB);
        o_sts.text_mode  = i_cfg.frame_mode == gpw_pkg::MODE_TEXT;
        o_sts.hit        = w_font[3'd7 - r_c] && (r_cx < i_cfg.frame_width)
                        && (r_cy < i_cfg.frame_height);
        o_sts.col_last   = r_c == 3'd7;
        o_sts.row_last   = r_r == 3'd7;
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = w_out_free;
        o_sts.can_push   = w_can_push;
    end

    // Input beat layout: char_code, pos_x, pos_y, colour, glyph_row, row_bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_s_tuser;
            r_code   <= i_s_tdata[7:0];
            r_x      <= i_s_tdata[19:8];
            r_y      <= i_s_tdata[31:20];
            r_colour <= i_s_tdata[63:32];
            r_grow   <= i_s_tdata[66:64];
            r_bits   <= i_s_tdata[74:67];
            r_cx     <= {1'b0, i_s_tdata[19:8]};
            r_cy     <= {1'b0, i_s_tdata[31:20]};
            r_c      <= 3'd0;
            r_r      <= 3'd0;
        end
        if (i_cmd.setup) begin
            r_row_off  <= r_y * i_cfg.line_pitch;
            r_col_base <= r_x * i_cfg.pixel_bytes;
            r_col_off  <= 16'(r_x * i_cfg.pixel_bytes);
            r_text_off <= 28'({w_text_sum, 1'b0});
        end
        if (i_cmd.step) begin
            if (r_c == 3'd7) begin
                r_c       <= 3'd0;
                r_r       <= r_r + 3'd1;
                r_cx      <= {1'b0, r_x};
                r_cy      <= r_cy + 13'd1;
                r_row_off <= r_row_off + 28'(i_cfg.line_pitch);
                r_col_off <= 16'(r_col_base);
            end else begin
                r_c       <= r_c + 3'd1;
                r_cx      <= r_cx + 13'd1;
                r_col_off <= r_col_off + 16'(i_cfg.pixel_bytes);
            end
        end
        if (i_cmd.push) begin
            r_pend <= w_cand;
        end
        if (i_cmd.flush || (i_cmd.push && r_pend_valid)) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.flush || (i_cmd.push && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {2'b00, r_out.byte_third, r_out.byte_second, r_out.byte_first,
                         r_out.byte_count, r_out.byte_offset};

endmodule

`default_nettype wire

>>> hdl/glyph_pixel_writer.sv
// Glyph pixel writer: turns draw requests into framebuffer byte writes.
// Top level with the configuration registers; depends on gpw_pkg, gpw_ctrl,
// gpw_dp and gpw_ram.
//
// Items arrive on the slave stream; tuser carries the action (load font row,
// draw glyph, draw pixel). Writes leave on the master stream, one beat per
// write, with tlast on the last write that an item causes. Items that cause
// no write give no beat. Configuration registers are written through the cfg
// channel, which is always ready; the user must write them only while the
// block is idle, which the block itself does not enforce. One item is
// worked on at a time. A load, or an item dropped for its position, mode or
// code, ends at dispatch; a pixel or a text cell adds a write and a flush
// step, and a glyph in a pixel mode scans its 64 font pixels out of the font
// RAM one per cycle unless stalled. Each write is held back until the next
// one or the end of the item is known, so a write reaches the output in the
// cycle after the next set pixel is scanned, and the last one after the flush
// step that follows the scan. A stalled receiver holds the output beat; the
// scan waits when a new write finds both the held-back write and the output
// beat occupied, and the next item is taken while the final beat waits.
// Reset restores the register defaults (text mode, 80 by 25) and empties the
// output. The font store is not cleared; glyphs must be loaded before use.
`default_nettype none

module glyph_pixel_writer #(
    parameter int GLYPH_COUNT = gpw_pkg::GLYPH_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // char_code[7:0], pos_x[19:8], pos_y[31:20], colour[63:32],
    // glyph_row[66:64], row_bits[74:67], zeros above.
    input  wire logic [gpw_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // action[1:0].
    input  wire logic [gpw_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // byte_offset[27:0], byte_count[29:28], byte_first[37:30],
    // byte_second[45:38], byte_third[53:46], zeros above.
    output logic      [gpw_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gpw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gpw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    gpw_pkg::t_cfg r_cfg;
    gpw_pkg::t_cfg n_cfg;
    gpw_pkg::t_cmd w_cmd;
    gpw_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                gpw_pkg::REG_MODE:   n_cfg.frame_mode   = i_cfg_data[1:0];
                gpw_pkg::REG_WIDTH:  n_cfg.frame_width  = i_cfg_data[12:0];
                gpw_pkg::REG_HEIGHT: n_cfg.frame_height = i_cfg_data[12:0];
                gpw_pkg::REG_PITCH:  n_cfg.line_pitch   = i_cfg_data;
                gpw_pkg::REG_PBYTES: n_cfg.pixel_bytes  = i_cfg_data[2:0];
                gpw_pkg::REG_RED:    n_cfg.red_shift    = i_cfg_data[4:0];
                gpw_pkg::REG_GREEN:  n_cfg.green_shift  = i_cfg_data[4:0];
                gpw_pkg::REG_BLUE:   n_cfg.blue_shift   = i_cfg_data[4:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= gpw_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gpw_dp #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> !w_sts.pend_valid)
        else $error("Item taken while a write of the previous item is held back.");

    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[29:28] == gpw_pkg::CNT_INDEXED
                     || o_m_tdata[29:28] == gpw_pkg::CNT_TEXT
                     || o_m_tdata[29:28] == gpw_pkg::CNT_RGB))
        else $error("Output beat carries an invalid byte count.");

    a_text_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[29:28] == gpw_pkg::CNT_TEXT) |-> !o_m_tdata[0])
        else $error("Text cell write at an odd byte offset.");

endmodule

`default_nettype wire
